>>> hdl/piecewise_linear_interpolator_assert.svh
// Assertion macros for the piecewise linear interpolator.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pli_pkg.sv
// Shared constants and types for the piecewise linear interpolator.
// No dependencies; imported by the top level.
package pli_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int WL_W       = 16;
  localparam int VAL_W      = 16;
  localparam int ENTRY_W    = WL_W + VAL_W;
  localparam int PORT_IDX_W = 8;
  localparam int CFG_W      = 9;
  localparam int ALU_W      = WL_W + 1;
  localparam int PROD_W     = WL_W + VAL_W;
  localparam int DIV_CNT_W  = $clog2(VAL_W);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LO_RD,
    S_LO_CAP,
    S_HI_RD,
    S_HI_CAP,
    S_DY,
    S_MUL,
    S_DIV,
    S_FIN
  } pli_state_t;

endpackage

>>> hdl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: breakpoint RAM, search and divide sequencer.
// Depends on pli_pkg, pli_ram and piecewise_linear_interpolator_assert.svh.
//
// Breakpoint lookup with linear interpolation. A write request (in_req_type low)
// stores one (wavelength, value) pair; busy never rises for it and no result
// follows. A query request binary-searches the first point_count entries for
// the first key at or above in_query_wavelength, one RAM read and one compare
// per step, so a table of n points takes at most ceil(log2(n+1)) steps.
// Queries at or below the first key, or above the last, return the end value;
// an empty table answers 0 in the cycle after the request. Interpolated queries
// fetch both neighbours, form (q - x0)*|y1 - y0| in one multiply, then divide by
// (x1 - x0) through a shared 17-bit subtractor, one quotient bit per cycle.
// Neighbours with equal or descending keys return the lower value instead.
// That subtractor also serves the search compares and the operand differences.
// The result appears on out_interpolated_value for exactly one cycle, marked by
// out_valid, in the cycle busy falls; the receiver cannot stall it, so capture
// it then. Entries are expected in ascending key order and must be written
// before any query reaches them. point_count sits at APB byte address 0 and
// may only be changed while busy is low.
`include "piecewise_linear_interpolator_assert.svh"

module piecewise_linear_interpolator
  import pli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // requests
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [PORT_IDX_W-1:0] in_entry_index,
  input  logic [WL_W-1:0]       in_entry_wavelength,
  input  logic [VAL_W-1:0]      in_entry_value,
  input  logic [WL_W-1:0]       in_query_wavelength,
  // results
  output logic                  out_valid,
  output logic [VAL_W-1:0]      out_interpolated_value
);

  pli_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  point_count_r, point_count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;

  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [WL_W-1:0]   q_r, q_nxt;
  logic [WL_W-1:0]   x0_r, x0_nxt;
  logic [VAL_W-1:0]  y0_r, y0_nxt;
  logic [VAL_W-1:0]  y1_r, y1_nxt;
  logic [WL_W-1:0]   num_r, num_nxt;
  logic [WL_W-1:0]   dx_r, dx_nxt;
  logic [VAL_W-1:0]  dy_mag_r, dy_mag_nxt;
  logic              neg_r, neg_nxt;
  logic [WL_W-1:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0]  quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic              cfg_wr;
  logic              cfg_reg_idx;
  logic              req_acc;
  logic              query_acc;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [WL_W-1:0]   rd_wl;
  logic [VAL_W-1:0]  rd_val;
  logic [CNT_W-1:0]  n_clamp;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  lo_dec;

  logic [ALU_W-1:0]  alu_a, alu_b;
  logic [ALU_W:0]    alu_diff;
  logic              alu_borrow;
  logic [ALU_W-1:0]  div_trial;
  logic [PROD_W-1:0] prod;

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait states, point_count is the only register
  // ---------------------------------------------------------------------------
  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_reg_idx = paddr[APB_ADDR_W-1];

  always_comb begin
    point_count_nxt = point_count_r;
    if (cfg_wr && (cfg_reg_idx == REG_POINT_COUNT)) begin
      point_count_nxt = pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (cfg_reg_idx == REG_POINT_COUNT) ? APB_DATA_W'(point_count_r) : '0;

  // ---------------------------------------------------------------------------
  // Request acceptance; writes go straight into the RAM
  // ---------------------------------------------------------------------------
  assign busy      = (state_r != S_IDLE);
  assign req_acc   = start & ~busy;
  assign query_acc = req_acc & (in_req_type == REQ_QUERY);
  // drop writes beyond the table
  assign ram_we    = req_acc & (in_req_type == REQ_WRITE) &
                     (32'(in_entry_index) < 32'(MAX_POINTS));

  // clamp an oversized count to the table depth
  assign n_clamp = (32'(point_count_r) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(point_count_r);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign lo_dec  = lo_r - 1'b1;

  // Read address: search probe, then lower and upper neighbours of the hit.
  // A hit at entry 0 fetches entry 0 as the lower neighbour.
  always_comb begin
    unique case (state_r)
      S_SRCH_RD: ram_raddr = IDX_W'(mid);
      S_LO_RD:   ram_raddr = (lo_r == '0) ? '0 : IDX_W'(lo_dec);
      S_HI_RD:   ram_raddr = IDX_W'(lo_r);
      default:   ram_raddr = '0;
    endcase
  end

  pli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_entry_index)),
    .wdata ({in_entry_wavelength, in_entry_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_wl  = ram_rdata[ENTRY_W-1:VAL_W];
  assign rd_val = ram_rdata[VAL_W-1:0];

  // ---------------------------------------------------------------------------
  // Shared subtractor: operands chosen by the sequencer state
  // ---------------------------------------------------------------------------
  assign div_trial = {rem_r, quo_r[VAL_W-1]};

  always_comb begin
    unique case (state_r)
      S_SRCH_CMP: begin
        alu_a = ALU_W'(rd_wl);
        alu_b = ALU_W'(q_r);
      end
      S_LO_CAP: begin
        alu_a = ALU_W'(q_r);
        alu_b = ALU_W'(rd_wl);
      end
      S_HI_CAP: begin
        alu_a = ALU_W'(rd_wl);
        alu_b = ALU_W'(x0_r);
      end
      S_DY: begin
        alu_a = ALU_W'(y1_r);
        alu_b = ALU_W'(y0_r);
      end
      S_DIV: begin
        alu_a = div_trial;
        alu_b = ALU_W'(dx_r);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[ALU_W];

  // registered straight into the divider's remainder and quotient
  assign prod = {{VAL_W{1'b0}}, num_r} * {{WL_W{1'b0}}, dy_mag_r};

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_acc && (n_clamp != '0)) begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD:  state_nxt = (lo_r == hi_r) ? S_LO_RD : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_LO_RD:    state_nxt = S_LO_CAP;
      S_LO_CAP: begin
        // below the first key or above the last: clamp, no interpolation
        state_nxt = ((lo_r == '0) || (lo_r == n_r)) ? S_IDLE : S_HI_RD;
      end
      S_HI_RD:    state_nxt = S_HI_CAP;
      S_HI_CAP: begin
        // equal or descending neighbours: return the lower value
        state_nxt = (alu_borrow || (alu_diff[WL_W-1:0] == '0)) ? S_IDLE : S_DY;
      end
      S_DY:       state_nxt = S_MUL;
      S_MUL:      state_nxt = S_DIV;
      S_DIV:      state_nxt = (cnt_r == '0) ? S_FIN : S_DIV;
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    n_nxt         = n_r;
    q_nxt         = q_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    num_nxt       = num_r;
    dx_nxt        = dx_r;
    dy_mag_nxt    = dy_mag_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (query_acc) begin
          q_nxt  = in_query_wavelength;
          lo_nxt = '0;
          hi_nxt = n_clamp;
          n_nxt  = n_clamp;
          if (n_clamp == '0) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '0;
          end
        end
      end
      S_SRCH_CMP: begin
        // key below the query: advance the lower bound, else pull in the upper
        if (alu_borrow) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
      end
      S_LO_CAP: begin
        x0_nxt  = rd_wl;
        y0_nxt  = rd_val;
        num_nxt = alu_diff[WL_W-1:0];
        if ((lo_r == '0) || (lo_r == n_r)) begin
          out_valid_nxt = 1'b1;
          res_nxt       = rd_val;
        end
      end
      S_HI_CAP: begin
        y1_nxt = rd_val;
        dx_nxt = alu_diff[WL_W-1:0];
        if (alu_borrow || (alu_diff[WL_W-1:0] == '0)) begin
          out_valid_nxt = 1'b1;
          res_nxt       = y0_r;
        end
      end
      S_DY: begin
        // divide magnitudes; the sign goes back on at the end
        neg_nxt    = alu_borrow;
        dy_mag_nxt = alu_borrow ? (~alu_diff[VAL_W-1:0] + 1'b1) : alu_diff[VAL_W-1:0];
      end
      S_MUL: begin
        // upper half is already below the divisor, so VAL_W steps suffice
        rem_nxt = prod[PROD_W-1:VAL_W];
        quo_nxt = prod[VAL_W-1:0];
        cnt_nxt = DIV_CNT_W'(VAL_W - 1);
      end
      S_DIV: begin
        rem_nxt = alu_borrow ? div_trial[WL_W-1:0] : alu_diff[WL_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], ~alu_borrow};
        cnt_nxt = cnt_r - 1'b1;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        res_nxt       = neg_r ? (y0_r - quo_r) : (y0_r + quo_r);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      point_count_r <= point_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    n_r      <= n_nxt;
    q_r      <= q_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    y1_r     <= y1_nxt;
    num_r    <= num_nxt;
    dx_r     <= dx_nxt;
    dy_mag_r <= dy_mag_nxt;
    neg_r    <= neg_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = res_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PLI_ASSERT_NEXT(a_write_no_result, req_acc && (in_req_type == REQ_WRITE), !out_valid,
    "write request produced a result")
  `PLI_ASSERT_SAME(a_result_when_idle, out_valid, !busy,
    "result strobe while the sequencer is still busy")
  `PLI_ASSERT_SAME(a_search_bounds, (state_r == S_SRCH_RD) || (state_r == S_SRCH_CMP),
    (lo_r <= hi_r) && (hi_r <= n_r), "search window out of range")
  `PLI_ASSERT_SAME(a_div_remainder, state_r == S_DIV, rem_r < dx_r,
    "divider remainder not below divisor")

endmodule

>>> tb/sv/piecewise_linear_interpolator_test.sv
// Self-checking testbench for the piecewise linear interpolator: breakpoint writes and
// interpolation queries, each answer checked against a built-in predictor.
// Depends on pli_pkg and the piecewise_linear_interpolator top level.
module piecewise_linear_interpolator_test;
  import pli_pkg::*;

  // Slowest correct run: about 630 requests, each with its busy stretch plus a
  // sender gap, and some 20 register pauses; far below this ceiling.
  localparam int CYCLE_LIMIT    = 1_000_000;
  // Longest busy stretch is a full-table interpolation; settle a little longer.
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_REQUESTS = 12;
  localparam int RANDOM_PHASES  = 11;
  localparam int MISMATCH_SHOWN = 10;

  localparam logic [APB_ADDR_W-1:0] POINT_COUNT_ADDR = APB_ADDR_W'(4 * REG_POINT_COUNT);

  // One request as it sits in the pending queue, one field per input port.
  typedef struct {
    logic                  req_type;
    logic [PORT_IDX_W-1:0] index;
    logic [WL_W-1:0]       wavelength;
    logic [VAL_W-1:0]      value;
    logic [WL_W-1:0]       query;
  } lookup_req_t;

  logic                  clk                 = 1'b0;
  logic                  rst_n               = 1'b0;
  logic                  psel                = 1'b0;
  logic                  penable             = 1'b0;
  logic                  pwrite              = 1'b0;
  logic [APB_ADDR_W-1:0] paddr               = '0;
  logic [APB_DATA_W-1:0] pwdata              = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start               = 1'b0;
  logic                  busy;
  logic                  in_req_type         = REQ_WRITE;
  logic [PORT_IDX_W-1:0] in_entry_index      = '0;
  logic [WL_W-1:0]       in_entry_wavelength = '0;
  logic [VAL_W-1:0]      in_entry_value      = '0;
  logic [WL_W-1:0]       in_query_wavelength = '0;
  logic                  out_valid;
  logic [VAL_W-1:0]      out_interpolated_value;

  // Requests waiting for the driver, and answers owed by the block, oldest first.
  lookup_req_t      request_queue [$];
  logic [VAL_W-1:0] efficiency_due [$];

  // Predictor state: breakpoint table and count as the block should hold them.
  logic [WL_W-1:0]  bp_wavelength [MAX_POINTS];
  logic [VAL_W-1:0] bp_value      [MAX_POINTS];
  logic [CFG_W-1:0] active_count = '0;

  // Planning copy of the table, kept as requests are queued, so that new
  // writes and queries can be aimed at the table the block will hold by then.
  logic [WL_W-1:0]  plan_wavelength [MAX_POINTS];
  logic [VAL_W-1:0] plan_value      [MAX_POINTS];

  int unsigned gap_pct      = 0;
  int unsigned gap_pcts [4] = '{0, 69, 0, 17};
  int unsigned fixed_counts [6] = '{0, 1, 2, 256, 511, 300};
  logic        req_taken    = 1'b0;
  int          mismatches   = 0;
  int          cycle_count  = 0;

  piecewise_linear_interpolator dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .start                  (start),
    .busy                   (busy),
    .in_req_type            (in_req_type),
    .in_entry_index         (in_entry_index),
    .in_entry_wavelength    (in_entry_wavelength),
    .in_entry_value         (in_entry_value),
    .in_query_wavelength    (in_query_wavelength),
    .out_valid              (out_valid),
    .out_interpolated_value (out_interpolated_value)
  );

  always #5 clk = ~clk;

  // Expected efficiency for a query against the current table: scan upward for
  // the first key at or above q, clamp at either end, else interpolate between
  // the neighbours with the quotient truncated toward zero.
  function automatic logic [VAL_W-1:0] interpolated_efficiency(input logic [WL_W-1:0] q);
    int     n;
    int     hit;
    longint x0, x1, y0, y1;
    n = (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
    if (n == 0) return '0;
    hit = n;
    for (int i = 0; i < n && hit == n; i++)
      if (bp_wavelength[i] >= q) hit = i;
    if (hit == 0) return bp_value[0];
    if (hit == n) return bp_value[n-1];
    x0 = longint'(bp_wavelength[hit-1]);
    x1 = longint'(bp_wavelength[hit]);
    y0 = longint'(bp_value[hit-1]);
    y1 = longint'(bp_value[hit]);
    // equal neighbouring keys: hold the lower breakpoint's value
    if (x1 <= x0) return bp_value[hit-1];
    return VAL_W'(y0 + ((longint'(q) - x0) * (y1 - y0)) / (x1 - x0));
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MISMATCH_SHOWN)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // Queue a breakpoint write; the unused query field carries noise.
  task automatic push_write(input logic [PORT_IDX_W-1:0] idx, input logic [WL_W-1:0] wl,
                            input logic [VAL_W-1:0] val);
    lookup_req_t r;
    r.req_type   = REQ_WRITE;
    r.index      = idx;
    r.wavelength = wl;
    r.value      = val;
    r.query      = WL_W'($urandom);
    plan_wavelength[idx] = wl;
    plan_value[idx]      = val;
    request_queue.push_back(r);
  endtask

  // Queue a query; the unused entry fields carry noise.
  task automatic push_query(input logic [WL_W-1:0] q);
    lookup_req_t r;
    r.req_type   = REQ_QUERY;
    r.index      = PORT_IDX_W'($urandom);
    r.wavelength = WL_W'($urandom);
    r.value      = VAL_W'($urandom);
    r.query      = q;
    request_queue.push_back(r);
  endtask

  // Wait until every queued request has gone in and every answer has come
  // back, then let the block run down before anything touches the register.
  task automatic settle;
    while (request_queue.size() != 0 || start || efficiency_due.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write point_count over the configuration port, then read it back.
  task automatic write_point_count(input logic [CFG_W-1:0] cnt);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POINT_COUNT_ADDR;
    pwdata  <= APB_DATA_W'(cnt);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_count = cnt;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(cnt))
      note_mismatch("point_count readback", longint'(cnt), longint'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request side, rising edge: a request goes in when start is high and busy
  // low. Apply writes to the predictor table; owe one answer per query.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      req_taken <= 1'b1;
      if (in_req_type == REQ_WRITE) begin
        bp_wavelength[in_entry_index] = in_entry_wavelength;
        bp_value[in_entry_index]      = in_entry_value;
      end else begin
        efficiency_due.push_back(interpolated_efficiency(in_query_wavelength));
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Driver, falling edge: hold a request until it is taken, then either
  // present the next one or leave a gap, as the phase's gap rate says.
  always @(negedge clk) begin : drive_requests
    lookup_req_t r;
    if (rst_n && (!start || req_taken)) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        r = request_queue.pop_front();
        in_req_type         <= r.req_type;
        in_entry_index      <= r.index;
        in_entry_wavelength <= r.wavelength;
        in_entry_value      <= r.value;
        in_query_wavelength <= r.query;
        start               <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result side: every strobe must match the oldest answer owed.
  always @(posedge clk) begin : check_results
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid) begin
      if (efficiency_due.size() == 0) begin
        note_mismatch("result with no query waiting", 0, longint'(out_interpolated_value));
      end else begin
        want = efficiency_due.pop_front();
        if (out_interpolated_value !== want)
          note_mismatch("interpolated_value", longint'(want),
                        longint'(out_interpolated_value));
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned cnt;
    int          m;
    int          prev_m;
    int          key;
    int          step_cap;
    int          lo;
    int          hi;
    int          i;
    int          j;
    int          tmp;
    int          sel;
    int          q;
    bit          narrow;
    int          order     [MAX_POINTS];
    int          fresh_key [MAX_POINTS];

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table first, both ends of the query range.
    gap_pct = 0;
    push_query(16'h0000);
    push_query(16'hFFFF);
    // Small table with a repeated key, a falling slope down to zero at the
    // very top of the range, and the highest index written off to one side.
    push_write(8'd0,   16'h0640, 16'h1000);
    push_write(8'd1,   16'h0C80, 16'hF000);
    push_write(8'd2,   16'h0C80, 16'h8000);
    push_write(8'd3,   16'hFFFF, 16'h0000);
    push_write(8'd255, 16'hFFFF, 16'hFFFF);
    push_query(16'h1234);
    // Single point: everything clamps to it.
    write_point_count(9'd1);
    push_query(16'h0000);
    push_query(16'h0640);
    push_query(16'hFFFF);
    // Four points: below, on and between keys, either side of the repeat,
    // and the falling segment where truncation goes toward zero.
    write_point_count(9'd4);
    push_query(16'h0000);
    push_query(16'h0640);
    push_query(16'h0641);
    push_query(16'h0960);
    push_query(16'h0C80);
    push_query(16'h0C81);
    push_query(16'h8000);
    push_query(16'hFFFE);
    push_query(16'hFFFF);
    // Three points: above the last key clamps to the last value.
    write_point_count(9'd3);
    push_query(16'h0C81);
    push_query(16'hFFFF);

    // Random phases: empty, tiny, full and over-full counts first, then
    // small tables. Each phase sets the count, rebuilds the table when its
    // size changes, then mixes queries with order-keeping writes.
    prev_m = -1;
    for (int p = 0; p < 6 + RANDOM_PHASES; p++) begin
      cnt     = (p < 6) ? fixed_counts[p] : $urandom_range(24, 3);
      gap_pct = gap_pcts[p % 4];
      write_point_count(CFG_W'(cnt));
      m = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);

      if (m != prev_m && m != 0) begin
        // Ascending keys; a narrow step cap now and then gives repeated keys.
        narrow = ($urandom_range(3) == 0);
        key    = $urandom_range(32767);
        for (int k = 0; k < m; k++) begin
          if (k > 0) begin
            step_cap = (65535 - key) / (m - k);
            if (narrow && step_cap > 2) step_cap = 2;
            key += $urandom_range(step_cap);
          end
          fresh_key[k] = key;
          order[k]     = k;
        end
        // Shuffle the write order; no query goes in before the table is whole.
        for (int k = m - 1; k > 0; k--) begin
          j        = $urandom_range(k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < m; k++)
          push_write(PORT_IDX_W'(order[k]), WL_W'(fresh_key[order[k]]), VAL_W'($urandom));
      end
      prev_m = m;

      repeat (PHASE_REQUESTS) begin
        if ($urandom_range(99) < 20) begin
          if (m == 0) begin
            push_write(PORT_IDX_W'($urandom), WL_W'($urandom), VAL_W'($urandom));
          end else if (m < MAX_POINTS && $urandom_range(3) == 0) begin
            // outside the active span: must not change any answer
            push_write(PORT_IDX_W'($urandom_range(MAX_POINTS - 1, m)), WL_W'($urandom),
                       VAL_W'($urandom));
          end else begin
            // rewrite an active entry between its neighbours' keys
            i  = $urandom_range(m - 1);
            lo = (i > 0) ? int'(plan_wavelength[i-1]) : 0;
            hi = (i < m - 1) ? int'(plan_wavelength[i+1]) : 65535;
            push_write(PORT_IDX_W'(i), WL_W'($urandom_range(hi, lo)), VAL_W'($urandom));
          end
        end else begin
          sel = $urandom_range(99);
          if (m == 0 || sel >= 85) begin
            q = $urandom;
          end else if (sel < 40 && m > 1) begin
            i = $urandom_range(m - 1, 1);
            q = $urandom_range(plan_wavelength[i], plan_wavelength[i-1]);
          end else if (sel < 55) begin
            q = int'(plan_wavelength[$urandom_range(m - 1)]);
          end else if (sel < 70) begin
            q = $urandom_range(plan_wavelength[0]);
          end else begin
            q = $urandom_range(65535, plan_wavelength[m-1]);
          end
          push_query(WL_W'(q));
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/piecewise_linear_interpolator.sv
tb/sv/piecewise_linear_interpolator_test.sv
